// ===== rtl/core/cbba_pkg.sv =====
// ---------------------------------------------------------------------------
// cbba_pkg
// Shared types, codes and constants of the contiguous block bitmap allocator.
// ---------------------------------------------------------------------------
package cbba_pkg;

  localparam int DEF_MAX_BLOCKS = 1024;
  localparam int WORD_W         = 8;
  localparam int WSH            = $clog2(WORD_W);
  localparam int SIZE_W         = 23;
  localparam int BS_W           = 13;
  localparam int BC_W           = 11;
  localparam int CNT_W          = 24;
  localparam int SUM_W          = 25;
  localparam int BLK_W          = 10;
  localparam int CFG_W          = 13;
  localparam int DIV_STEPS      = SIZE_W;
  localparam int DCNT_W         = $clog2(DIV_STEPS + 1);

  localparam logic [BS_W-1:0] RST_BLOCK_SIZE  = 13'd64;
  localparam logic [BC_W-1:0] RST_BLOCK_COUNT = 11'd1024;

  typedef enum logic [1:0] {
    OP_CREATE   = 2'd0,
    OP_DELETE   = 2'd1,
    OP_TRUNCATE = 2'd2,
    OP_NONE     = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_NO_FREE = 2'd1,
    ST_COMPACT = 2'd2
  } status_t;

  typedef enum logic [0:0] {
    CFG_BLOCK_SIZE  = 1'b0,
    CFG_BLOCK_COUNT = 1'b1
  } cfg_idx_t;

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_DISPATCH, S_DIV_CUR, S_DIV_NEW, S_DECIDE, S_RD, S_PROC, S_DONE
  } state_t;

  typedef enum logic [2:0] {
    RS_CREATE, RS_DELETE, RS_GROW_CHK, RS_GROW_SET, RS_SHRINK
  } range_sel_t;

  typedef enum logic [1:0] {
    FS_START, FS_ZERO, FS_FOUND
  } first_sel_t;

  typedef struct packed {
    op_t               operation;
    logic [BLK_W-1:0]  start_block;
    logic [SIZE_W-1:0] current_size;
    logic [SIZE_W-1:0] new_size;
  } in_t;

  typedef struct packed {
    status_t          status;
    logic [BLK_W-1:0] first_block;
  } out_t;

  typedef struct packed {
    logic       clr_step;
    logic       load;
    logic       div_start_cur;
    logic       div_start_new;
    logic       div_step;
    logic       save_old;
    logic       save_new;
    logic       range_init;
    range_sel_t sel;
    logic       rd;
    logic       proc;
    logic       out_load;
    status_t    status;
    first_sel_t first_sel;
  } cmd_t;

  typedef struct packed {
    logic       clr_done;
    logic       div_done;
    op_t        op;
    range_sel_t sel;
    logic       range_done;
    logic       hit;
    logic       grow;
    logic       shrink;
    logic       fits;
  } stat_t;

endpackage

// ===== rtl/core/cbba_ram.sv =====
// ---------------------------------------------------------------------------
// cbba_ram
// Generic single write port, single read port RAM with registered read.
// ---------------------------------------------------------------------------
module cbba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128,
  parameter int AW    = 7
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/cbba_dp.sv =====
// ---------------------------------------------------------------------------
// cbba_dp
// Datapath: config registers, size divider, range bounds, bitmap word walk.
// ---------------------------------------------------------------------------
module cbba_dp
  import cbba_pkg::*;
#(
  parameter int MAX_BLOCKS = DEF_MAX_BLOCKS
) (
  input  logic             clk,
  input  logic             rst_n,
  input  cmd_t             cmd,
  output stat_t            st,
  input  in_t              in_data,
  output out_t             out_data,
  input  logic             cfg_we,
  input  logic [0:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_data
);

  localparam int WORDS   = MAX_BLOCKS / WORD_W;
  localparam int WADDR_W = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int PTR_W   = WADDR_W + 1;
  localparam int BW      = PTR_W + WSH;
  localparam logic [SUM_W-1:0] MAXV = SUM_W'(MAX_BLOCKS);

  logic [BS_W-1:0]   bs_r;
  logic [BC_W-1:0]   bc_r;
  in_t               in_r;
  logic [SIZE_W-1:0] quo_r;
  logic [BS_W-1:0]   rem_r;
  logic [DCNT_W-1:0] dcnt_r;
  logic [CNT_W-1:0]  oldn_r, newn_r;
  range_sel_t        sel_r;
  logic [BW-1:0]     lo_r, hi_r;
  logic [PTR_W-1:0]  ptr_r;
  status_t           status_r;
  logic [BLK_W-1:0]  first_r;

  logic [BS_W-1:0]   bs_eff;
  logic [BS_W:0]     shifted;
  logic              qbit;
  logic [CNT_W-1:0]  div_n_raw, div_n;
  logic [SUM_W-1:0]  effc, start_s, s_old, s_new, lo_s, hi_s;
  logic [BW-1:0]     lo_c, hi_c;
  logic [WORD_W-1:0] rdata, mask, cand, used, wword;
  logic [WSH-1:0]    fj;
  logic [BW-1:0]     found_idx;
  logic [31:0]       found32;
  logic              wr_ok, ram_we;
  logic [WORD_W-1:0] ram_wdata;

  function automatic logic [BW-1:0] clamp(input logic [SUM_W-1:0] v);
    return (v > MAXV) ? BW'(MAX_BLOCKS) : v[BW-1:0];
  endfunction

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bs_r <= RST_BLOCK_SIZE;
      bc_r <= RST_BLOCK_COUNT;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_BLOCK_SIZE:  bs_r <= cfg_data;
        CFG_BLOCK_COUNT: bc_r <= cfg_data[BC_W-1:0];
        default: ;
      endcase
    end
  end

  // restoring divider step, ceiling and floor of one
  assign bs_eff    = (bs_r == '0) ? BS_W'(1) : bs_r;
  assign shifted   = {rem_r, quo_r[SIZE_W-1]};
  assign qbit      = (shifted >= {1'b0, bs_eff});
  assign div_n_raw = CNT_W'(quo_r) + CNT_W'(rem_r != '0);
  assign div_n     = (div_n_raw == '0) ? CNT_W'(1) : div_n_raw;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dcnt_r <= '0;
    end else if (cmd.div_start_cur || cmd.div_start_new) begin
      dcnt_r <= DCNT_W'(DIV_STEPS);
    end else if (cmd.div_step) begin
      dcnt_r <= dcnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start_new) begin
      quo_r <= in_r.new_size;
      rem_r <= '0;
    end else if (cmd.div_start_cur) begin
      quo_r <= in_r.current_size;
      rem_r <= '0;
    end else if (cmd.div_step) begin
      quo_r <= {quo_r[SIZE_W-2:0], qbit};
      rem_r <= qbit ? BS_W'(shifted - {1'b0, bs_eff}) : shifted[BS_W-1:0];
    end
  end

  // item and block count capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      in_r <= in_data;
    end
    if (cmd.save_old) begin
      oldn_r <= div_n;
    end
    if (cmd.save_new) begin
      newn_r <= div_n;
    end
  end

  // range bounds
  assign effc    = (SUM_W'(bc_r) > MAXV) ? MAXV : SUM_W'(bc_r);
  assign start_s = SUM_W'(in_r.start_block);
  assign s_old   = start_s + SUM_W'(oldn_r);
  assign s_new   = start_s + SUM_W'(newn_r);

  always_comb begin
    lo_s = '0;
    hi_s = effc;
    case (cmd.sel)
      RS_CREATE:   begin lo_s = '0;      hi_s = effc;  end
      RS_DELETE:   begin lo_s = start_s; hi_s = s_old; end
      RS_GROW_CHK: begin lo_s = s_old;   hi_s = s_new; end
      RS_GROW_SET: begin lo_s = start_s; hi_s = s_new; end
      RS_SHRINK:   begin lo_s = s_new;   hi_s = s_old; end
      default:     begin lo_s = '0;      hi_s = '0;    end
    endcase
  end

  assign lo_c = clamp(lo_s);
  assign hi_c = clamp(hi_s);

  always_ff @(posedge clk) begin
    if (cmd.range_init) begin
      sel_r <= cmd.sel;
      lo_r  <= lo_c;
      hi_r  <= hi_c;
    end
  end

  // word pointer, shared by the clearing pass and the range walk
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r <= '0;
    end else if (cmd.range_init) begin
      ptr_r <= lo_c[BW-1:WSH];
    end else if (cmd.clr_step || cmd.proc) begin
      ptr_r <= ptr_r + 1'b1;
    end
  end

  // per-word mask, search and update
  always_comb begin
    logic [BW-1:0] idx;
    mask = '0;
    for (int j = 0; j < WORD_W; j++) begin
      idx     = {ptr_r, WSH'(j)};
      mask[j] = (idx >= lo_r) && (idx < hi_r);
    end
  end

  assign cand = mask & ~rdata;
  assign used = mask & rdata;

  always_comb begin
    fj = '0;
    for (int j = WORD_W - 1; j >= 0; j--) begin
      if (cand[j]) begin
        fj = WSH'(j);
      end
    end
  end

  assign found_idx = {ptr_r, fj};
  assign found32   = 32'(found_idx);

  always_comb begin
    wword = rdata;
    wr_ok = 1'b1;
    case (sel_r)
      RS_CREATE:   begin wword = rdata | (WORD_W'(1) << fj); wr_ok = |cand; end
      RS_GROW_CHK: begin wword = rdata; wr_ok = 1'b0; end
      RS_GROW_SET: begin wword = rdata | mask; end
      default:     begin wword = rdata & ~mask; end
    endcase
  end

  assign ram_we    = cmd.clr_step || (cmd.proc && wr_ok);
  assign ram_wdata = cmd.clr_step ? '0 : wword;

  cbba_ram #(
    .WIDTH (WORD_W),
    .DEPTH (WORDS),
    .AW    (WADDR_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ptr_r[WADDR_W-1:0]),
    .wdata (ram_wdata),
    .re    (cmd.rd),
    .raddr (ptr_r[WADDR_W-1:0]),
    .rdata (rdata)
  );

  // result registers
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      status_r <= cmd.status;
      case (cmd.first_sel)
        FS_ZERO:  first_r <= '0;
        FS_FOUND: first_r <= found32[BLK_W-1:0];
        default:  first_r <= in_r.start_block;
      endcase
    end
  end

  assign out_data.status      = status_r;
  assign out_data.first_block = first_r;

  // status back to the controller
  assign st.clr_done   = (ptr_r == PTR_W'(WORDS - 1));
  assign st.div_done   = (dcnt_r == '0);
  assign st.op         = in_r.operation;
  assign st.sel        = sel_r;
  assign st.range_done = (lo_r >= hi_r) || ({ptr_r, WSH'(0)} >= hi_r);
  assign st.hit        = (sel_r == RS_GROW_CHK) ? (|used) : (|cand);
  assign st.grow       = (newn_r > oldn_r);
  assign st.shrink     = (oldn_r > newn_r);
  assign st.fits       = (s_new <= effc);

endmodule

// ===== rtl/core/cbba_ctrl.sv =====
// ---------------------------------------------------------------------------
// cbba_ctrl
// Controller: sequences clearing, division, range walks and the result beat.
// ---------------------------------------------------------------------------
module cbba_ctrl
  import cbba_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  start,
  output logic  busy,
  output logic  out_strobe,
  output cmd_t  cmd,
  input  stat_t st
);

  state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLR:      if (st.clr_done) state_nxt = S_IDLE;
      S_IDLE:     if (start) state_nxt = S_DISPATCH;
      S_DISPATCH: begin
        case (st.op)
          OP_CREATE:   state_nxt = S_RD;
          OP_DELETE:   state_nxt = S_DIV_CUR;
          OP_TRUNCATE: state_nxt = S_DIV_CUR;
          default:     state_nxt = S_DONE;
        endcase
      end
      S_DIV_CUR: begin
        if (st.div_done) state_nxt = (st.op == OP_TRUNCATE) ? S_DIV_NEW : S_DECIDE;
      end
      S_DIV_NEW:  if (st.div_done) state_nxt = S_DECIDE;
      S_DECIDE: begin
        if (st.op == OP_DELETE) state_nxt = S_RD;
        else if (st.grow) state_nxt = st.fits ? S_RD : S_DONE;
        else if (st.shrink) state_nxt = S_RD;
        else state_nxt = S_DONE;
      end
      S_RD: begin
        if (!st.range_done) state_nxt = S_PROC;
        else if (st.sel == RS_GROW_CHK) state_nxt = S_RD;
        else state_nxt = S_DONE;
      end
      S_PROC: begin
        if (st.hit && (st.sel == RS_CREATE || st.sel == RS_GROW_CHK)) state_nxt = S_DONE;
        else state_nxt = S_RD;
      end
      S_DONE:     state_nxt = S_IDLE;
      default:    state_nxt = S_CLR;
    endcase
  end

  // commands
  always_comb begin
    cmd = '0;
    cmd.sel = RS_CREATE;
    cmd.status = ST_DONE;
    cmd.first_sel = FS_START;
    case (state_r)
      S_CLR:  cmd.clr_step = 1'b1;
      S_IDLE: cmd.load = start;
      S_DISPATCH: begin
        case (st.op)
          OP_CREATE: begin
            cmd.range_init = 1'b1;
            cmd.sel = RS_CREATE;
          end
          OP_DELETE:   cmd.div_start_cur = 1'b1;
          OP_TRUNCATE: cmd.div_start_cur = 1'b1;
          default:     cmd.out_load = 1'b1;
        endcase
      end
      S_DIV_CUR: begin
        if (!st.div_done) begin
          cmd.div_step = 1'b1;
        end else begin
          cmd.save_old = 1'b1;
          cmd.div_start_new = (st.op == OP_TRUNCATE);
        end
      end
      S_DIV_NEW: begin
        cmd.div_step = !st.div_done;
        cmd.save_new = st.div_done;
      end
      S_DECIDE: begin
        if (st.op == OP_DELETE) begin
          cmd.range_init = 1'b1;
          cmd.sel = RS_DELETE;
        end else if (st.grow && st.fits) begin
          cmd.range_init = 1'b1;
          cmd.sel = RS_GROW_CHK;
        end else if (st.grow) begin
          cmd.out_load = 1'b1;
          cmd.status = ST_COMPACT;
        end else if (st.shrink) begin
          cmd.range_init = 1'b1;
          cmd.sel = RS_SHRINK;
        end else begin
          cmd.out_load = 1'b1;
        end
      end
      S_RD: begin
        if (!st.range_done) begin
          cmd.rd = 1'b1;
        end else if (st.sel == RS_GROW_CHK) begin
          cmd.range_init = 1'b1;
          cmd.sel = RS_GROW_SET;
        end else if (st.sel == RS_CREATE) begin
          cmd.out_load = 1'b1;
          cmd.status = ST_NO_FREE;
          cmd.first_sel = FS_ZERO;
        end else begin
          cmd.out_load = 1'b1;
        end
      end
      S_PROC: begin
        cmd.proc = 1'b1;
        if (st.hit && st.sel == RS_CREATE) begin
          cmd.out_load = 1'b1;
          cmd.first_sel = FS_FOUND;
        end else if (st.hit && st.sel == RS_GROW_CHK) begin
          cmd.out_load = 1'b1;
          cmd.status = ST_COMPACT;
        end
      end
      default: ;
    endcase
  end

  assign busy       = (state_r != S_IDLE);
  assign out_strobe = (state_r == S_DONE);

endmodule

// ===== rtl/core/contiguous_block_bitmap_allocator_top.sv =====
// ---------------------------------------------------------------------------
// contiguous_block_bitmap_allocator_top
// Create: scans the bitmap word by word, each 8-block word read, then searched and its first free block set.
// Delete and truncate: each size takes 23 divider steps and a capture, then each
// 8-block bitmap word touched is read, then written back (a grow check only reads).
// One item at a time; the result beat is one cycle and cannot be stalled.
// Reset: busy while the clearing pass zeroes every bitmap word.
// ---------------------------------------------------------------------------
module contiguous_block_bitmap_allocator_top
  import cbba_pkg::*;
#(
  parameter int MAX_BLOCKS = DEF_MAX_BLOCKS
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  in_t              in_data,
  output logic             out_strobe,
  output out_t             out_data,
  input  logic             cfg_we,
  input  logic [0:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_data
);

  cmd_t  cmd;
  stat_t st;

  // sequencer
  cbba_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .out_strobe (out_strobe),
    .cmd        (cmd),
    .st         (st)
  );

  // datapath and bitmap
  cbba_dp #(
    .MAX_BLOCKS (MAX_BLOCKS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .st        (st),
    .in_data   (in_data),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // result beat lasts one cycle
  a_strobe_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe) else $error("result strobe longer than one cycle");

  // an accepted item makes the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("not busy after accept");

  // strobe only while an item is in flight
  a_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> busy) else $error("strobe while idle");

  // a full disk reports block zero
  a_nofree_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_data.status == ST_NO_FREE) |-> (out_data.first_block == '0))
    else $error("no-free result with nonzero block");

endmodule
